// File: src/ovrf_pkg.sv
// Shared types and constants for the overwrite ring FIFO.
// No dependencies; every other file of the block but ovrf_slot_mem imports this package.
package ovrf_pkg;

    localparam int MODE_W   = 2;
    localparam int DATA_W   = 64;
    localparam int BYTES_W  = 4;
    localparam int OFFSET_W = 4;
    localparam int COUNT_W  = 4;

    // Operation codes carried in the mode field; the fourth code is unused
    typedef enum logic [MODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2
    } op_t;

endpackage

// File: src/ovrf_req_if.sv
// Request channel of the overwrite ring FIFO: valid/ready plus operation fields.
// Depends on ovrf_pkg.
interface ovrf_req_if;
    import ovrf_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [DATA_W-1:0]   write_data;
    logic [BYTES_W-1:0]  write_bytes;
    logic [OFFSET_W-1:0] peek_offset;

    modport source (output valid, mode, write_data, write_bytes, peek_offset, input ready);
    modport sink   (input valid, mode, write_data, write_bytes, peek_offset, output ready);
endinterface

// File: src/ovrf_rsp_if.sv
// Response channel of the overwrite ring FIFO: valid/ready plus result fields.
// Depends on ovrf_pkg.
interface ovrf_rsp_if;
    import ovrf_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [DATA_W-1:0]  read_data;
    logic               dropped_oldest;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               is_full;

    modport source (output valid, ok, read_data, dropped_oldest, entry_count, is_empty,
                    is_full, input ready);
    modport sink   (input valid, ok, read_data, dropped_oldest, entry_count, is_empty,
                    is_full, output ready);
endinterface

// File: src/overwrite_ring_fifo_core.sv
// Top level of the overwrite ring FIFO: request decode, pointers, count, response register.
// Depends on ovrf_pkg, ovrf_req_if, ovrf_rsp_if and ovrf_slot_mem.
//
//  Channel   | Dir | Handshake              | Payload
//  ----------+-----+------------------------+-------------------------------------------
//  req       | in  | valid/ready            | mode, write_data, write_bytes, peek_offset
//  rsp       | out | valid/ready            | ok, read_data, dropped_oldest, entry_count,
//            |     |                        | is_empty, is_full
//  cfg_we    | in  | write strobe, no wait  | cfg_wdata -> wrap_mode
//
//  Each request runs in two steps: the accept edge reads the addressed slot from the slot
//  memory, the execute step merges/writes it back, moves the pointers and loads the response
//  register. The registered read port of the slot memory makes the read a separate step.
//  The response register frees the request side: a new request is taken while the last
//  response waits, and the write-back step holds only while that response is still unclaimed.
//  Reset clears pointers, count, wrap mode and the slot valid flags at once; no clearing pass.
module overwrite_ring_fifo_core #(
    parameter int CAPACITY    = 15,
    parameter int ENTRY_BYTES = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    ovrf_req_if.sink         req,
    ovrf_rsp_if.source       rsp
);
    import ovrf_pkg::*;

    localparam int SLOTS   = CAPACITY + 1;
    localparam int PW      = $clog2(SLOTS);
    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = 8 * ENTRY_BYTES;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Ring state
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] count_reg, count_next;
    logic          wrap_reg;

    // Captured request
    logic [MODE_W-1:0]  op_reg;
    logic [DATA_W-1:0]  wdata_reg;
    logic [BYTES_W-1:0] nbytes_reg;

    // Response register
    logic               rsp_valid_reg;
    logic               ok_reg, ok_next;
    logic [ENTRY_W-1:0] rdata_reg, rdata_next;
    logic               dropped_reg, dropped_next;
    logic [CW-1:0]      rsp_count_reg;

    // Slot memory hookup
    logic               rd_en;
    logic [PW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;

    logic          req_fire;
    logic          exec_fire;
    logic          full;
    logic          empty;
    logic [PW-1:0] off_mod;
    logic [PW:0]   peek_sum;
    logic [PW-1:0] peek_addr;
    logic [PW:0]   ptr_dist;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == PW'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign exec_fire = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);

    // Fold the 4-bit offset into the slot range through a small constant table
    always_comb
    begin
        off_mod = '0;
        for (int i = 0; i < (1 << OFFSET_W); i++)
        begin
            if (req.peek_offset == OFFSET_W'(i))
            begin
                off_mod = PW'(i % SLOTS);
            end
        end
    end

    // Sum stays below twice the slot count, so one compare-subtract wraps it
    assign peek_sum  = {1'b0, rp_reg} + {1'b0, off_mod};
    assign peek_addr = (peek_sum >= (PW+1)'(SLOTS)) ? PW'(peek_sum - (PW+1)'(SLOTS))
                                                    : peek_sum[PW-1:0];

    // Issue the slot read on the accept edge
    assign rd_en = req_fire;
    always_comb
    begin
        unique case (req.mode)
            OP_WRITE: rd_addr = wp_reg;
            OP_POP:   rd_addr = rp_reg;
            OP_PEEK:  rd_addr = peek_addr;
            default:  rd_addr = rp_reg;
        endcase
    end

    // Merge the low write_bytes bytes over the old slot contents; bytes at or
    // above ENTRY_BYTES are never stored, which also saturates the count
    always_comb
    begin
        for (int b = 0; b < ENTRY_BYTES; b++)
        begin
            wr_data[8*b +: 8] = (BYTES_W'(b) < nbytes_reg) ? wdata_reg[8*b +: 8]
                                                           : rd_data[8*b +: 8];
        end
    end

    // Execute step: modify the ring state and build the response
    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        count_next   = count_reg;
        wr_en        = 1'b0;
        ok_next      = 1'b0;
        rdata_next   = '0;
        dropped_next = 1'b0;
        if (exec_fire)
        begin
            unique case (op_reg)
                OP_WRITE:
                begin
                    if (!full || wrap_reg)
                    begin
                        wr_en   = 1'b1;
                        ok_next = 1'b1;
                        wp_next = advance(wp_reg);
                        if (full)
                        begin
                            // Overwrite: drop the oldest, count stays at capacity
                            rp_next      = advance(rp_reg);
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                OP_POP:
                begin
                    if (!empty)
                    begin
                        ok_next    = 1'b1;
                        rdata_next = rd_data;
                        rp_next    = advance(rp_reg);
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_PEEK:
                begin
                    if (!empty)
                    begin
                        ok_next    = 1'b1;
                        rdata_next = rd_data;
                    end
                end
                default:
                begin
                    // Unused code: report the ring as it stands
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_fire) state_next = ST_EXEC;
            ST_EXEC: if (exec_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            wrap_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                wrap_reg <= cfg_wdata;
            end
            priority if (exec_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture the request, hold the response
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg     <= req.mode;
            wdata_reg  <= req.write_data;
            nbytes_reg <= req.write_bytes;
        end
        if (exec_fire)
        begin
            ok_reg        <= ok_next;
            rdata_reg     <= rdata_next;
            dropped_reg   <= dropped_next;
            rsp_count_reg <= count_next;
        end
    end

    ovrf_slot_mem #(
        .DEPTH (SLOTS),
        .AW    (PW),
        .DW    (ENTRY_W)
    ) u_slot_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data)
    );

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.ok             = ok_reg;
    assign rsp.read_data      = DATA_W'(rdata_reg);
    assign rsp.dropped_oldest = dropped_reg;
    assign rsp.entry_count    = COUNT_W'(rsp_count_reg);
    assign rsp.is_empty       = (rsp_count_reg == '0);
    assign rsp.is_full        = (rsp_count_reg == CW'(CAPACITY));

    // Distance between the pointers around the ring, for checking the count
    assign ptr_dist = (wp_reg >= rp_reg) ? ({1'b0, wp_reg} - {1'b0, rp_reg})
                                         : ({1'b0, wp_reg} + (PW+1)'(SLOTS) - {1'b0, rp_reg});

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_dist == (PW+1)'(count_reg))
        else $error("entry count disagrees with pointer distance");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_EXEC))
        else $error("accepted request did not reach the execute step");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && dropped_next) |-> (ok_next && full && wrap_reg && count_next == count_reg))
        else $error("drop of oldest entry outside a full wrap-mode write");

    a_rsp_load: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready && state_reg == ST_EXEC) |=> $stable(rsp_count_reg))
        else $error("pending response overwritten");

endmodule

// File: src/ovrf_slot_mem.sv
// Slot store: synchronous memory with one write and one registered read port.
// Per-slot valid flags make never-written slots read as zero after reset.
module ovrf_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0]    rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    // Mark slots once written; reset clears all the valid flags at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: sim/ovrf_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the overwrite ring FIFO testbench: result record and ring predictor class.
// Depends on ovrf_pkg for the field widths and operation codes.
package ovrf_tb_pkg;
    import ovrf_pkg::*;

    localparam int RING_CAPACITY    = 15;
    localparam int RING_ENTRY_BYTES = 8;
    localparam int RING_SLOTS       = RING_CAPACITY + 1;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  read_data;
        logic               dropped_oldest;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic               is_full;
    } ring_result_t;

    class ring_fifo_scoreboard;
        logic [DATA_W-1:0] slot_image [RING_SLOTS];
        int unsigned       wr_ptr;
        int unsigned       rd_ptr;
        bit                wrap_mode;
        ring_result_t      pending_results [$];
        int unsigned       error_count;
        int unsigned       checked_count;
        int unsigned       drop_count;
        int unsigned       refused_count;

        function new();
            for (int i = 0; i < RING_SLOTS; i++)
                slot_image[i] = '0;
            wr_ptr        = 0;
            rd_ptr        = 0;
            wrap_mode     = 1'b0;
            error_count   = 0;
            checked_count = 0;
            drop_count    = 0;
            refused_count = 0;
        endfunction

        function void set_wrap(bit value);
            wrap_mode = value;
        endfunction

        function bit idle();
            return pending_results.size() == 0;
        endfunction

        function int unsigned held_entries();
            return (wr_ptr + RING_SLOTS - rd_ptr) % RING_SLOTS;
        endfunction

        function int unsigned next_slot(int unsigned p);
            return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
        endfunction

        // Byte-lane mask for a write; counts above the entry size saturate
        function logic [DATA_W-1:0] lane_mask(int unsigned nbytes);
            int unsigned n;
            n = (nbytes > RING_ENTRY_BYTES) ? RING_ENTRY_BYTES : nbytes;
            if (n >= 8)
                return '1;
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        // Apply one accepted request to the ring image and queue its expected result
        function void note_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data,
                                   logic [BYTES_W-1:0] nbytes, logic [OFFSET_W-1:0] offset);
            ring_result_t      res;
            int unsigned       held_now;
            logic [DATA_W-1:0] mask;
            logic [DATA_W-1:0] entry_mask;
            bit                full;
            res        = '0;
            entry_mask = lane_mask(RING_ENTRY_BYTES);
            held_now   = held_entries();
            full       = (held_now == RING_CAPACITY);
            if (mode == OP_WRITE)
            begin
                if (!full || wrap_mode)
                begin
                    mask = lane_mask(nbytes);
                    slot_image[wr_ptr] = ((slot_image[wr_ptr] & ~mask) | (data & mask))
                                         & entry_mask;
                    wr_ptr = next_slot(wr_ptr);
                    if (full)
                    begin
                        rd_ptr = next_slot(rd_ptr);
                        res.dropped_oldest = 1'b1;
                        drop_count++;
                    end
                    res.ok = 1'b1;
                end
                else
                    refused_count++;
            end
            else if (mode == OP_POP)
            begin
                if (held_now != 0)
                begin
                    res.read_data = slot_image[rd_ptr] & entry_mask;
                    rd_ptr = next_slot(rd_ptr);
                    res.ok = 1'b1;
                end
                else
                    refused_count++;
            end
            else if (mode == OP_PEEK)
            begin
                if (held_now != 0)
                begin
                    res.read_data = slot_image[(rd_ptr + offset) % RING_SLOTS] & entry_mask;
                    res.ok = 1'b1;
                end
                else
                    refused_count++;
            end
            held_now = held_entries();
            res.entry_count = held_now[COUNT_W-1:0];
            res.is_empty    = (held_now == 0);
            res.is_full     = (held_now == RING_CAPACITY);
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_response(ring_result_t got);
            ring_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("response with no request pending");
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            checked_count++;
            compare_field("ok", DATA_W'(want.ok), DATA_W'(got.ok));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("dropped_oldest", DATA_W'(want.dropped_oldest),
                          DATA_W'(got.dropped_oldest));
            compare_field("entry_count", DATA_W'(want.entry_count), DATA_W'(got.entry_count));
            compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
            compare_field("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
        endfunction
    endclass

endpackage

// File: sim/overwrite_ring_fifo_core_tb.sv
`timescale 1ns / 1ps
// Top-level testbench of overwrite_ring_fifo_core: drives requests and wrap mode, checks responses.
// Depends on ovrf_pkg, ovrf_req_if, ovrf_rsp_if, ovrf_tb_pkg and the block's RTL.
module overwrite_ring_fifo_core_tb;
    import ovrf_pkg::*;
    import ovrf_tb_pkg::*;

    // Cycles without any handshake before the run is declared hung; the worst
    // stall profile idles 87 percent of the time, so a quiet run that long never occurs
    localparam int QUIET_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int PHASE_COUNT     = 8;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;

    ovrf_req_if req_ch ();
    ovrf_rsp_if rsp_ch ();

    ring_fifo_scoreboard ring_sb;
    ring_result_t        rsp_seen;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned request_count  = 0;
    bit          monitor_on     = 1'b0;

    always #4 clk = ~clk;

    overwrite_ring_fifo_core #(
        .CAPACITY    (RING_CAPACITY),
        .ENTRY_BYTES (RING_ENTRY_BYTES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Receiver: pick ready at every falling edge according to the stall profile
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Monitor and watchdog: sample both channels at the rising edge.
    // Check the response before noting a request taken at the same edge, so a
    // response that arrives with nothing pending is never matched to it.
    always @(posedge clk)
    begin
        if (monitor_on)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_seen.ok             = rsp_ch.ok;
                rsp_seen.read_data      = rsp_ch.read_data;
                rsp_seen.dropped_oldest = rsp_ch.dropped_oldest;
                rsp_seen.entry_count    = rsp_ch.entry_count;
                rsp_seen.is_empty       = rsp_ch.is_empty;
                rsp_seen.is_full        = rsp_ch.is_full;
                ring_sb.check_response(rsp_seen);
            end
            if (req_ch.valid && req_ch.ready)
            begin
                ring_sb.note_request(req_ch.mode, req_ch.write_data, req_ch.write_bytes,
                                     req_ch.peek_offset);
                request_count++;
            end
            if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                         QUIET_LIMIT, ring_sb.pending_results.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Present one request, optionally after idle cycles, and hold it until accepted.
    // Called and returning at a falling edge; valid stays high on return so a
    // back-to-back request needs only one assignment in that step.
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] data,
                           input logic [BYTES_W-1:0] nbytes,
                           input logic [OFFSET_W-1:0] offset);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.write_data  <= data;
        req_ch.write_bytes <= nbytes;
        req_ch.peek_offset <= offset;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write wrap mode only once the ring has answered everything outstanding
    task automatic write_wrap(input bit value);
        req_ch.valid <= 1'b0;
        while (!ring_sb.idle())
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        ring_sb.set_wrap(value);
    endtask

    // Mostly in-range byte counts, with zero and oversized counts mixed in
    function automatic logic [BYTES_W-1:0] pick_bytes();
        if ($urandom_range(0, 9) == 0)
            return BYTES_W'($urandom_range(0, 15));
        return BYTES_W'($urandom_range(1, 8));
    endfunction

    // Random traffic in bursts: fill runs push the ring to full (refusal or
    // overwrite), drain runs empty it, noise runs mix every code including the
    // unused one. Ignored requests do not count toward the phase size.
    task automatic run_phase(input int unsigned items);
        int unsigned       done;
        int unsigned       kind;
        int unsigned       len;
        logic [MODE_W-1:0] m;
        done = 0;
        while (done < items)
        begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(4, 20);
            for (int i = 0; i < len; i++)
            begin
                if (kind < 4)
                    m = ($urandom_range(0, 7) == 0) ? OP_PEEK : OP_WRITE;
                else if (kind < 7)
                    m = ($urandom_range(0, 5) == 0) ? OP_PEEK : OP_POP;
                else
                    m = MODE_W'($urandom_range(0, 3));
                send_op(m, {$urandom(), $urandom()}, pick_bytes(),
                        OFFSET_W'($urandom_range(0, 15)));
                if (m != MODE_UNUSED)
                    done++;
            end
        end
    endtask

    initial
    begin
        ring_sb = new();

        // Drive every input to a known value from time zero
        req_ch.valid       = 1'b0;
        req_ch.mode        = OP_WRITE;
        req_ch.write_data  = '0;
        req_ch.write_bytes = '0;
        req_ch.peek_offset = '0;
        rsp_ch.ready       = 1'b0;

        repeat (8) @(negedge clk);
        rst_n      <= 1'b1;
        monitor_on <= 1'b1;
        @(negedge clk);

        // Directed part, no idling on either side
        write_wrap(1'b0);
        send_op(OP_POP, '0, 4'd1, 4'd0);                    // pop on empty ring
        send_op(OP_PEEK, '0, 4'd1, 4'd7);                   // peek on empty ring
        send_op(MODE_UNUSED, '1, 4'd8, 4'd15);              // unused code, ignored
        send_op(OP_WRITE, '1, 4'd0, 4'd0);                  // zero bytes: entry, no data
        send_op(OP_PEEK, '0, 4'd1, 4'd0);
        send_op(OP_PEEK, '0, 4'd1, 4'd15);                  // past held entries, never written
        send_op(OP_WRITE, '1, 4'd8, 4'd0);
        send_op(OP_WRITE, 64'h0123_4567_89AB_CDEF, 4'd9, 4'd0);   // count saturates
        send_op(OP_WRITE, '0, 4'd1, 4'd0);
        send_op(OP_WRITE, 64'hA5A5_A5A5_A5A5_A5A5, 4'd15, 4'd0);
        send_op(OP_POP, '0, 4'd1, 4'd0);
        for (int i = 0; i < 11; i++)
            send_op(OP_WRITE, {$urandom(), $urandom()}, pick_bytes(), 4'd0);
        send_op(OP_WRITE, '1, 4'd8, 4'd0);                  // full, wrap off: refused
        send_op(OP_PEEK, '0, 4'd1, 4'd15);                  // lands on the spare slot
        write_wrap(1'b1);
        send_op(OP_WRITE, 64'h5A5A_0000_FFFF_1234, 4'd8, 4'd3);   // overwrite, drop oldest
        send_op(OP_POP, '0, 4'd1, 4'd0);

        // Random part: both wrap settings under each handshake profile
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_wrap(p[0]);
            case (p / 2)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 87;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 87;
                end
                default:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            run_phase(ITEMS_PER_PHASE);
        end

        // Drain: drop valid, wait for every response, then let the pipeline settle
        req_ch.valid <= 1'b0;
        recv_stall_pct = 0;
        while (!ring_sb.idle())
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Covered %0d requests (%0d responses checked) over %0d phases, both wrap",
                 request_count, ring_sb.checked_count, PHASE_COUNT);
        $display("settings and four handshake profiles; %0d overwrites, %0d refusals, %0d errors",
                 ring_sb.drop_count, ring_sb.refused_count, ring_sb.error_count);
        if (ring_sb.error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
